>>> sv/sagclip_pkg.sv
// ----------------------------------------------------------------------------
// sagclip_pkg
// Shared types and constants for the sag envelope soft clipper: the request
// and response of the bit-serial arithmetic unit and the fixed-point constants.
// ----------------------------------------------------------------------------
package sagclip_pkg;

  // Arithmetic unit widths
  localparam int ALU_AW = 36;   // multiplicand and multiplier
  localparam int ALU_PW = 72;   // product
  localparam int ALU_NW = 64;   // dividend and quotient
  localparam int ALU_DW = 32;   // divisor and remainder
  localparam int ALU_CW = 7;    // iteration counter

  localparam logic [ALU_CW-1:0] MUL_CYCLES = 7'd36;
  localparam logic [ALU_CW-1:0] DIV_CYCLES = 7'd64;

  // Configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 24;

  localparam logic [CFG_IW-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_RELEASE = 3'd1;
  localparam logic [CFG_IW-1:0] REG_SAG_AMT = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SAG_DB  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_DRIVE   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_CHANS   = 3'd5;

  // Fixed-point constants
  localparam logic [ALU_AW-1:0] LN2_Q32        = 36'd2977044472;
  localparam logic [ALU_AW-1:0] DB_TO_LOG2_Q32 = 36'd713378626;
  localparam logic [ALU_AW-1:0] TWO_LOG2E_Q24  = 36'd48408813;
  localparam logic [30:0]       ONE_Q30        = 31'd1073741824;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [ALU_AW-1:0] a;
    logic [ALU_AW-1:0] b;
    logic [ALU_NW-1:0] n;
    logic [ALU_DW-1:0] d;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [ALU_PW-1:0] result;
  } alu_rsp_t;

endpackage

>>> sv/sag_envelope_soft_clipper.sv
// ----------------------------------------------------------------------------
// sag_envelope_soft_clipper
// Peak envelope follower with decibel sag gain and tanh soft clip per frame.
// One frame is in work at a time, and the sag gain and the clip have short-cut
// paths. Products and quotients come from the shared bit-serial unit.
// Synchronous active-low reset restores the register defaults, clears envelope.
// ----------------------------------------------------------------------------
module sag_envelope_soft_clipper #(
  parameter int SAMPLE_BITS  = 24,
  parameter int MAX_CHANNELS = 2
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_BITS-1:0]         in_raw_left,
  input  logic signed [SAMPLE_BITS-1:0]         in_raw_right,
  input  logic signed [SAMPLE_BITS-1:0]         in_filtered_left,
  input  logic signed [SAMPLE_BITS-1:0]         in_filtered_right,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_BITS-1:0]         out_left,
  output logic signed [SAMPLE_BITS-1:0]         out_right,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sagclip_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [sagclip_pkg::CFG_DW-1:0]        cfg_data
);
  import sagclip_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int FRAC = SAMPLE_BITS - 1;
  localparam int YW   = FRAC + 32;
  localparam int SH_R = (FRAC > 23) ? FRAC - 23 : 0;
  localparam int SH_L = (FRAC < 23) ? 23 - FRAC : 0;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  // Microprogram steps
  localparam logic [4:0] ST_ENV  = 5'd0;
  localparam logic [4:0] ST_GAIN = 5'd1;
  localparam logic [4:0] ST_G1   = 5'd2;
  localparam logic [4:0] ST_G2   = 5'd3;
  localparam logic [4:0] ST_G3   = 5'd4;
  localparam logic [4:0] ST_POW  = 5'd5;
  localparam logic [4:0] ST_PZ   = 5'd6;
  localparam logic [4:0] ST_PZ2  = 5'd7;
  localparam logic [4:0] ST_PZ3  = 5'd8;
  localparam logic [4:0] ST_PD3  = 5'd9;
  localparam logic [4:0] ST_PZ4  = 5'd10;
  localparam logic [4:0] ST_PD4  = 5'd11;
  localparam logic [4:0] ST_PSQ  = 5'd12;
  localparam logic [4:0] ST_PSH  = 5'd13;
  localparam logic [4:0] ST_RET  = 5'd14;
  localparam logic [4:0] ST_C1   = 5'd15;
  localparam logic [4:0] ST_C2   = 5'd16;
  localparam logic [4:0] ST_C3   = 5'd17;
  localparam logic [4:0] ST_C4   = 5'd18;
  localparam logic [4:0] ST_C5   = 5'd19;

  state_t state_r, state_nxt;
  logic [4:0] step_r, step_nxt;

  // Configuration
  logic [23:0]        attack_r, release_r;
  logic [16:0]        sag_amt_r;
  logic signed [15:0] sag_db_r;
  logic [13:0]        drive_cfg_r;
  logic [1:0]         chan_cfg_r;

  // Work registers
  logic [SB-1:0] env_r, env_nxt;
  logic [SB-1:0] peak_r, peak_nxt;
  logic [SB-1:0] diff_r, diff_nxt;
  logic          ge_r, ge_nxt;
  logic [23:0]   coeff_r, coeff_nxt;
  logic [SB-1:0] fl_r, fl_nxt, fr_r, fr_nxt;
  logic          ch_r, ch_nxt;
  logic          chans2_r, chans2_nxt;
  logic [30:0]   gain_r, gain_nxt;
  logic [14:0]   m_r, m_nxt;
  logic [45:0]   e_r, e_nxt;
  logic [28:0]   z_r, z_nxt, zk_r, zk_nxt;
  logic [33:0]   p_r, p_nxt;
  logic [30:0]   pw_r, pw_nxt;
  logic [1:0]    sq_r, sq_nxt;
  logic          clip_call_r, clip_call_nxt;
  logic [34:0]   ad_r, ad_nxt;
  logic [30:0]   tq_r, tq_nxt, cm_r, cm_nxt;
  logic [SB-1:0] yl_r, yl_nxt, yr_r, yr_nxt;
  logic [SB-1:0] out_left_r, out_left_nxt, out_right_r, out_right_nxt;
  logic          out_valid_r, out_valid_nxt;

  alu_req_t req;
  alu_rsp_t rsp;

  // Helpers
  logic [SB-1:0]     mag_l, mag_r, pk, env_one, envc;
  logic [13:0]       drive;
  logic [15:0]       negdb;
  logic [SB-1:0]     cur_s, cur_mag;
  logic              cur_neg;
  logic [ALU_PW-1:0] res, env_sum, g2_sum, r29_sum, ad_full;
  logic [16:0]       m17;
  logic [33:0]       psum;
  logic [30:0]       num;
  logic [31:0]       den;
  logic [YW-1:0]     ys;
  logic [FRAC+1:0]   mo, mm, lim_neg, lim_pos, mneg;
  logic [SB-1:0]     outv;
  logic              in_acc;

  sagclip_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    mag_l   = in_raw_left[SB-1] ? $unsigned(~in_raw_left + 1'b1) : $unsigned(in_raw_left);
    mag_r   = in_raw_right[SB-1] ? $unsigned(~in_raw_right + 1'b1) : $unsigned(in_raw_right);
    chans2_nxt = chans2_r;
    if (in_acc) begin
      chans2_nxt = (chan_cfg_r != 2'd1) && (MAX_CHANNELS > 1);
    end
    pk      = (chans2_nxt && (mag_r > mag_l)) ? mag_r : mag_l;
    env_one = SB'(1) << FRAC;
    envc    = (env_r > env_one) ? env_one : env_r;
    drive   = (drive_cfg_r < 14'd256) ? 14'd256 : drive_cfg_r;
    negdb   = ~sag_db_r + 16'd1;
    cur_s   = ch_r ? fr_r : fl_r;
    cur_neg = cur_s[SB-1];
    cur_mag = cur_neg ? (~cur_s + 1'b1) : cur_s;

    res     = rsp.result;
    env_sum = res + (72'd1 << 23);
    g2_sum  = res + (72'd1 << (FRAC + 15));
    m17     = g2_sum[FRAC+16 +: 17];
    r29_sum = res + (72'd1 << 29);
    ad_full = (res >> SH_R) << SH_L;
    psum    = p_r + 34'(res[28:0]) + 34'd2;
    num     = ONE_Q30 - pw_r;
    den     = 32'(ONE_Q30) + 32'(pw_r);

    // Round the clipped value to the sample grid and saturate
    ys      = (YW'(r29_sum[60:30]) << FRAC) + (YW'(1) << 29);
    mo      = ys[YW-1:30];
    lim_neg = (FRAC+2)'(1) << FRAC;
    lim_pos = lim_neg - 1'b1;
    if (cur_neg) begin
      mm   = (mo > lim_neg) ? lim_neg : mo;
      mneg = ~mm + 1'b1;
      outv = mneg[SB-1:0];
    end else begin
      mm   = (mo > lim_pos) ? lim_pos : mo;
      mneg = mm;
      outv = mm[SB-1:0];
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    env_nxt       = env_r;
    peak_nxt      = peak_r;
    diff_nxt      = diff_r;
    ge_nxt        = ge_r;
    coeff_nxt     = coeff_r;
    fl_nxt        = fl_r;
    fr_nxt        = fr_r;
    ch_nxt        = ch_r;
    gain_nxt      = gain_r;
    m_nxt         = m_r;
    e_nxt         = e_r;
    z_nxt         = z_r;
    zk_nxt        = zk_r;
    p_nxt         = p_r;
    pw_nxt        = pw_r;
    sq_nxt        = sq_r;
    clip_call_nxt = clip_call_r;
    ad_nxt        = ad_r;
    tq_nxt        = tq_r;
    cm_nxt        = cm_r;
    yl_nxt        = yl_r;
    yr_nxt        = yr_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_valid_nxt = out_valid_r && !out_ready;

    req.start = 1'b0;
    req.op    = ALU_MUL;
    req.a     = '0;
    req.b     = '0;
    req.n     = '0;
    req.d     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          peak_nxt  = pk;
          ge_nxt    = (env_r >= pk);
          diff_nxt  = (env_r >= pk) ? env_r - pk : pk - env_r;
          coeff_nxt = (pk > env_r) ? attack_r : release_r;
          fl_nxt    = in_filtered_left;
          fr_nxt    = in_filtered_right;
          ch_nxt    = 1'b0;
          yr_nxt    = '0;
          step_nxt  = ST_ENV;
          state_nxt = S_RUN;
        end
      end

      S_RUN: begin
        state_nxt = S_WAIT;
        req.start = 1'b1;
        case (step_r)
          ST_ENV: begin
            req.a = ALU_AW'(diff_r);
            req.b = ALU_AW'(coeff_r);
          end
          ST_GAIN: begin
            req.start = 1'b0;
            state_nxt = S_RUN;
            if (!sag_db_r[15]) begin
              gain_nxt = ONE_Q30;
              step_nxt = ST_C1;
            end else begin
              step_nxt = ST_G1;
            end
          end
          ST_G1: begin
            req.a = ALU_AW'(negdb);
            req.b = ALU_AW'(sag_amt_r);
          end
          ST_G2: begin
            req.a = ALU_AW'(e_r[32:0]);
            req.b = ALU_AW'(envc);
          end
          ST_G3: begin
            req.a = DB_TO_LOG2_Q32;
            req.b = ALU_AW'(m_r);
          end
          ST_POW: begin
            req.start = 1'b0;
            state_nxt = S_RUN;
            if (e_r[45:40] >= 6'd31) begin
              pw_nxt   = '0;
              step_nxt = ST_RET;
            end else begin
              step_nxt = ST_PZ;
            end
          end
          ST_PZ: begin
            req.a = LN2_Q32;
            req.b = ALU_AW'(e_r[39:8]);
          end
          ST_PZ2, ST_PZ3, ST_PZ4: begin
            req.a = ALU_AW'(zk_r);
            req.b = ALU_AW'(z_r);
          end
          ST_PD3: begin
            req.op = ALU_DIV;
            req.n  = ALU_NW'(zk_r);
            req.d  = 32'd6;
          end
          ST_PD4: begin
            req.op = ALU_DIV;
            req.n  = ALU_NW'(zk_r);
            req.d  = 32'd24;
          end
          ST_PSQ: begin
            req.a = ALU_AW'(pw_r);
            req.b = ALU_AW'(pw_r);
          end
          ST_PSH: begin
            req.start = 1'b0;
            state_nxt = S_RUN;
            pw_nxt    = pw_r >> e_r[44:40];
            step_nxt  = ST_RET;
          end
          ST_RET: begin
            req.start = 1'b0;
            state_nxt = S_RUN;
            if (clip_call_r) begin
              step_nxt = ST_C3;
            end else begin
              gain_nxt = pw_r;
              step_nxt = ST_C1;
            end
          end
          ST_C1: begin
            req.a = ALU_AW'(cur_mag);
            req.b = ALU_AW'(drive);
          end
          ST_C2: begin
            req.a = ALU_AW'(ad_r);
            req.b = TWO_LOG2E_Q24;
          end
          ST_C3: begin
            req.op = ALU_DIV;
            req.n  = (ALU_NW'(num) << 30) + ALU_NW'(den >> 1);
            req.d  = den;
          end
          ST_C4: begin
            req.op = ALU_DIV;
            req.n  = (ALU_NW'(tq_r) << 8) + ALU_NW'(drive >> 1);
            req.d  = ALU_DW'(drive);
          end
          ST_C5: begin
            req.a = ALU_AW'(cm_r);
            req.b = ALU_AW'(gain_r);
          end
          default: begin
            req.start = 1'b0;
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_WAIT: begin
        if (rsp.done) begin
          state_nxt = S_RUN;
          case (step_r)
            ST_ENV: begin
              env_nxt  = ge_r ? peak_r + env_sum[24 +: SB] : peak_r - env_sum[24 +: SB];
              step_nxt = ST_GAIN;
            end
            ST_G1: begin
              e_nxt    = res[45:0];
              step_nxt = ST_G2;
            end
            ST_G2: begin
              if (m17 >= 17'd25600) begin
                gain_nxt = '0;
                step_nxt = ST_C1;
              end else begin
                m_nxt    = m17[14:0];
                step_nxt = ST_G3;
              end
            end
            ST_G3: begin
              e_nxt         = res[45:0];
              clip_call_nxt = 1'b0;
              step_nxt      = ST_POW;
            end
            ST_PZ: begin
              z_nxt    = res[63:35];
              zk_nxt   = res[63:35];
              p_nxt    = (34'd1 << 32) - 34'(res[63:35]);
              step_nxt = ST_PZ2;
            end
            ST_PZ2: begin
              zk_nxt   = res[60:32];
              p_nxt    = p_r + 34'(res[60:33]);
              step_nxt = ST_PZ3;
            end
            ST_PZ3: begin
              zk_nxt   = res[60:32];
              step_nxt = ST_PD3;
            end
            ST_PD3: begin
              p_nxt    = p_r - 34'(res[28:0]);
              step_nxt = ST_PZ4;
            end
            ST_PZ4: begin
              zk_nxt   = res[60:32];
              step_nxt = ST_PD4;
            end
            ST_PD4: begin
              pw_nxt   = psum[32:2];
              sq_nxt   = '0;
              step_nxt = ST_PSQ;
            end
            ST_PSQ: begin
              pw_nxt = r29_sum[60:30];
              sq_nxt = sq_r + 1'b1;
              if (sq_r == 2'd2) begin
                step_nxt = ST_PSH;
              end
            end
            ST_C1: begin
              if (ad_full >= (72'd12 << 31)) begin
                pw_nxt   = '0;
                step_nxt = ST_C3;
              end else begin
                ad_nxt   = ad_full[34:0];
                step_nxt = ST_C2;
              end
            end
            ST_C2: begin
              e_nxt         = res[60:15];
              clip_call_nxt = 1'b1;
              step_nxt      = ST_POW;
            end
            ST_C3: begin
              tq_nxt   = res[30:0];
              step_nxt = ST_C4;
            end
            ST_C4: begin
              cm_nxt   = res[30:0];
              step_nxt = ST_C5;
            end
            ST_C5: begin
              if (!ch_r) begin
                yl_nxt = outv;
                if (chans2_r) begin
                  ch_nxt   = 1'b1;
                  step_nxt = ST_C1;
                end else begin
                  state_nxt = S_OUT;
                end
              end else begin
                yr_nxt    = outv;
                state_nxt = S_OUT;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_left_nxt  = yl_r;
          out_right_nxt = yr_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      env_r       <= '0;
      attack_r    <= 24'd16000000;
      release_r   <= 24'd16770000;
      sag_amt_r   <= 17'd0;
      sag_db_r    <= -16'sd1536;
      drive_cfg_r <= 14'd512;
      chan_cfg_r  <= 2'd2;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      env_r       <= env_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ATTACK:  attack_r    <= cfg_data[23:0];
          REG_RELEASE: release_r   <= cfg_data[23:0];
          REG_SAG_AMT: sag_amt_r   <= cfg_data[16:0];
          REG_SAG_DB:  sag_db_r    <= cfg_data[15:0];
          REG_DRIVE:   drive_cfg_r <= cfg_data[13:0];
          REG_CHANS:   chan_cfg_r  <= cfg_data[1:0];
          default: begin
          end
        endcase
      end
    end
    step_r      <= step_nxt;
    peak_r      <= peak_nxt;
    diff_r      <= diff_nxt;
    ge_r        <= ge_nxt;
    coeff_r     <= coeff_nxt;
    fl_r        <= fl_nxt;
    fr_r        <= fr_nxt;
    ch_r        <= ch_nxt;
    chans2_r    <= chans2_nxt;
    gain_r      <= gain_nxt;
    m_r         <= m_nxt;
    e_r         <= e_nxt;
    z_r         <= z_nxt;
    zk_r        <= zk_nxt;
    p_r         <= p_nxt;
    pw_r        <= pw_nxt;
    sq_r        <= sq_nxt;
    clip_call_r <= clip_call_nxt;
    ad_r        <= ad_nxt;
    tq_r        <= tq_nxt;
    cm_r        <= cm_nxt;
    yl_r        <= yl_nxt;
    yr_r        <= yr_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

endmodule

>>> sv/sagclip_alu.sv
// ----------------------------------------------------------------------------
// sagclip_alu
// Bit-serial multiplier and restoring divider sharing one sequencer. A product
// takes one multiplier bit per cycle, a quotient one dividend bit per cycle.
// ----------------------------------------------------------------------------
module sagclip_alu (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sagclip_pkg::alu_req_t req,
  output sagclip_pkg::alu_rsp_t rsp
);
  import sagclip_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  alu_op_t           op_r, op_nxt;
  logic [ALU_CW-1:0] cnt_r, cnt_nxt;
  logic [ALU_PW-1:0] acc_r, acc_nxt;
  logic [ALU_AW-1:0] mcand_r, mcand_nxt;
  logic [ALU_NW-1:0] quo_r, quo_nxt;
  logic [ALU_DW-1:0] rem_r, rem_nxt;
  logic [ALU_DW-1:0] div_r, div_nxt;

  logic [ALU_AW:0]   msum;
  logic [ALU_DW:0]   r2;
  logic [ALU_DW:0]   rdiff;
  logic              ge;

  always_comb begin
    msum  = {1'b0, acc_r[ALU_PW-1:ALU_AW]} + (acc_r[0] ? {1'b0, mcand_r} : '0);
    r2    = {rem_r, quo_r[ALU_NW-1]};
    rdiff = r2 - {1'b0, div_r};
    ge    = (r2 >= {1'b0, div_r});

    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;

    if (req.start) begin
      busy_nxt  = 1'b1;
      op_nxt    = req.op;
      cnt_nxt   = (req.op == ALU_MUL) ? MUL_CYCLES : DIV_CYCLES;
      acc_nxt   = {{(ALU_PW-ALU_AW){1'b0}}, req.b};
      mcand_nxt = req.a;
      quo_nxt   = req.n;
      rem_nxt   = '0;
      div_nxt   = req.d;
    end else if (busy_r) begin
      if (op_r == ALU_MUL) begin
        acc_nxt = {msum, acc_r[ALU_AW-1:1]};
      end else begin
        rem_nxt = ge ? rdiff[ALU_DW-1:0] : r2[ALU_DW-1:0];
        quo_nxt = {quo_r[ALU_NW-2:0], ge};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r    <= op_nxt;
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = (op_r == ALU_MUL) ? acc_r : {{(ALU_PW-ALU_NW){1'b0}}, quo_r};

endmodule
